/* rtl/tts_pkg.sv */
// Shared types, constants and helpers of the template tag segment scanner.
`default_nettype none
package tts_pkg;

  localparam int unsigned MAX_LEN_DEF  = 1024;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned FIELD_W      = 11;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam logic [CHAR_W-1:0] DELIM_RST = 8'd64;  // '@'
  localparam logic [CHAR_W-1:0] SEP_RST   = 8'd58;  // ':'

  localparam logic [CFG_IDX_W-1:0] REG_TAG_DELIMITER     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SEPARATOR = 8'd1;

  localparam logic [1:0] KIND_PLAIN   = 2'd0;
  localparam logic [1:0] KIND_OPTION  = 2'd1;
  localparam logic [1:0] KIND_COMPARE = 2'd2;

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_INSIDE,
    PH_CLOSED
  } tts_phase_t;

  // Classification of one character, handed from front to back.
  typedef struct packed {
    logic term;    // end of string
    logic drop;    // beyond the maximum length
    logic pair_d;  // this and the previous character are the delimiter
    logic pair_s;  // this and the previous character are the separator
    logic oper;    // character of the operator set
  } tts_class_t;

  localparam int unsigned CLASS_W = $bits(tts_class_t);

  function automatic logic is_oper(input logic [CHAR_W-1:0] c);
    return (c == 8'h21) || (c == 8'h3D) || (c == 8'h3C) ||
           (c == 8'h3E) || (c == 8'h26) || (c == 8'h7C);
  endfunction

endpackage
`default_nettype wire

/* rtl/tts_in_if.sv */
// Character channel: one character or a terminator per word.
`default_nettype none
interface tts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       terminator;

  modport source (output valid, ch, terminator, input ready);
  modport sink (input valid, ch, terminator, output ready);
endinterface
`default_nettype wire

/* rtl/tts_out_if.sv */
// Result channel: tag and segment bounds of one string per word.
`default_nettype none
interface tts_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  segment_kind;
  logic [10:0] tag_start;
  logic [10:0] tag_end;
  logic [10:0] var_start;
  logic [10:0] var_end;
  logic [10:0] attr_start;
  logic [10:0] attr_end;
  logic [10:0] value_start;
  logic [10:0] value_end;
  logic        too_long;

  modport source (output valid, found, segment_kind, tag_start, tag_end, var_start,
                  var_end, attr_start, attr_end, value_start, value_end, too_long,
                  input ready);
  modport sink (input valid, found, segment_kind, tag_start, tag_end, var_start,
                var_end, attr_start, attr_end, value_start, value_end, too_long,
                output ready);
endinterface
`default_nettype wire

/* rtl/template_tag_segment_scanner_core.sv */
// Top level of the template tag segment scanner: front end, queue, back end.
//
//   channel    direction  word                           handshake
//   in_chan    in         ch, terminator                 valid/ready
//   out_res    out        found, kind, eight bounds,     valid/ready
//                         too_long
//   cfg_*      in         index, 8-bit data              write enable
//
// One character word per cycle sustained while the queue is not full; the front
// end classifies a word in the cycle it is taken, the back end consumes it from
// the queue in the next cycle if no word waits ahead of it, and the result word
// is registered: a terminator passes the queue entry, then the result register.
// Reset (rst_n low at a clock edge) restores '@' and ':' and clears the scan.
// A stalled result stalls only the back end; the queue absorbs up to four
// words before in_chan.ready drops.
`default_nettype none
module template_tag_segment_scanner_core
  import tts_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  tts_in_if.sink                    in_chan,
  tts_out_if.source                 out_res,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CHAR_W-1:0]    cfg_wdata
);
  // Position counter holds the maximum length itself.
  localparam int unsigned POS_W = $clog2(MAX_LEN + 1);
  localparam int unsigned QW    = CLASS_W + POS_W;

  logic             q_push, q_full, q_pop, q_not_empty;
  tts_class_t       f_class, b_class;
  logic [POS_W-1:0] f_pos, b_pos;
  logic [QW-1:0]    q_rdata;

  // Classify and hold the registers.
  tts_front #(.MAX_LEN(MAX_LEN), .POS_W(POS_W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_class   (f_class),
    .q_pos     (f_pos)
  );

  // Decouple the two halves.
  tts_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     ({f_class, f_pos}),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty)
  );

  assign b_class = tts_class_t'(q_rdata[QW-1:POS_W]);
  assign b_pos   = q_rdata[POS_W-1:0];

  // Track the tag and emit on the terminator word.
  tts_back #(.MAX_LEN(MAX_LEN), .POS_W(POS_W)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_class     (b_class),
    .q_pos       (b_pos),
    .q_pop       (q_pop),
    .out_res     (out_res)
  );
endmodule
`default_nettype wire

/* rtl/tts_queue.sv */
// Small register FIFO between the classifier and the scanner.
`default_nettype none
module tts_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  not_empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

/* rtl/tts_front.sv */
// Front end: takes characters, holds the registers, classifies each word.
`default_nettype none
module tts_front
  import tts_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF,
  parameter int unsigned POS_W   = $clog2(MAX_LEN + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  tts_in_if.sink                    in_chan,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CHAR_W-1:0]    cfg_wdata,
  input  wire logic                 q_full,
  output logic                      q_push,
  output tts_class_t                q_class,
  output logic [POS_W-1:0]          q_pos
);
  logic [CHAR_W-1:0] delim_r, sep_r;
  logic [CHAR_W-1:0] prev_r, prev_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;
  assign q_pos         = pos_r;

  always_comb begin
    q_class.term   = in_chan.terminator;
    q_class.drop   = !in_chan.terminator && (pos_r >= POS_W'(MAX_LEN));
    q_class.pair_d = (prev_r == delim_r) && (in_chan.ch == delim_r);
    q_class.pair_s = (prev_r == sep_r) && (in_chan.ch == sep_r);
    q_class.oper   = is_oper(in_chan.ch);
  end

  always_comb begin
    prev_nxt = prev_r;
    pos_nxt  = pos_r;
    if (q_push) begin
      if (q_class.term) begin
        prev_nxt = '0;
        pos_nxt  = '0;
      end else if (!q_class.drop) begin
        prev_nxt = in_chan.ch;
        pos_nxt  = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RST;
      sep_r   <= SEP_RST;
      prev_r  <= '0;
      pos_r   <= '0;
    end else begin
      prev_r <= prev_nxt;
      pos_r  <= pos_nxt;
      if (cfg_we && cfg_index == REG_TAG_DELIMITER) begin
        delim_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_SEGMENT_SEPARATOR) begin
        sep_r <= cfg_wdata;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/tts_back.sv */
// Back end: tracks tag and segment positions and builds the result word.
`default_nettype none
module tts_back
  import tts_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF,
  parameter int unsigned POS_W   = $clog2(MAX_LEN + 1)
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_not_empty,
  input  wire tts_class_t  q_class,
  input  wire logic [POS_W-1:0] q_pos,
  output logic             q_pop,
  tts_out_if.source        out_res
);
  localparam int unsigned W = (POS_W > FIELD_W) ? POS_W : FIELD_W;

  tts_phase_t       phase_r, phase_nxt;
  logic             pv_r, pv_nxt;
  logic [POS_W-1:0] open_r, open_nxt, close_r, close_nxt;
  logic [POS_W-1:0] sep1_r, sep1_nxt, sep2_r, sep2_nxt, oper_r, oper_nxt;
  logic             f1_r, f1_nxt, f2_r, f2_nxt, fo_r, fo_nxt;
  logic             ovf_r, ovf_nxt;
  logic             pair_d, pair_s, step;
  logic [POS_W-1:0] pos_m1;

  logic             out_valid_r;
  logic             found_r;
  logic [1:0]       kind_r;
  logic [FIELD_W-1:0] ts_r, te_r, vs_r, ve_r, as_r, ae_r, os_r, oe_r;
  logic             long_r;

  logic             found_c;
  logic [1:0]       kind_c;
  logic [W-1:0]     ae_w;
  logic [FIELD_W-1:0] ts_c, te_c, vs_c, ve_c, as_c, ae_c, os_c, oe_c;

  assign q_pop  = q_not_empty && (!q_class.term || !out_valid_r || out_res.ready);
  assign step   = q_pop && !q_class.term && !q_class.drop;
  assign pair_d = pv_r && q_class.pair_d;
  assign pair_s = pv_r && q_class.pair_s;
  assign pos_m1 = q_pos - 1'b1;

  // Phase sequencing.
  always_comb begin
    phase_nxt = phase_r;
    if (q_pop && q_class.term) begin
      phase_nxt = PH_SEEK;
    end else if (step) begin
      unique case (phase_r)
        PH_SEEK:   if (pair_d) phase_nxt = PH_INSIDE;
        PH_INSIDE: if (pair_d) phase_nxt = PH_CLOSED;
        PH_CLOSED: phase_nxt = PH_CLOSED;
        default:   phase_nxt = PH_SEEK;
      endcase
    end
  end

  // Position captures and match flags.
  always_comb begin
    pv_nxt    = pv_r;
    open_nxt  = open_r;
    close_nxt = close_r;
    sep1_nxt  = sep1_r;
    sep2_nxt  = sep2_r;
    oper_nxt  = oper_r;
    f1_nxt    = f1_r;
    f2_nxt    = f2_r;
    fo_nxt    = fo_r;
    ovf_nxt   = ovf_r;
    if (q_pop && q_class.term) begin
      pv_nxt    = 1'b0;
      open_nxt  = '0;
      close_nxt = '0;
      sep1_nxt  = '0;
      sep2_nxt  = '0;
      oper_nxt  = '0;
      f1_nxt    = 1'b0;
      f2_nxt    = 1'b0;
      fo_nxt    = 1'b0;
      ovf_nxt   = 1'b0;
    end else if (q_pop && q_class.drop) begin
      ovf_nxt = 1'b1;
    end else if (step) begin
      pv_nxt = 1'b1;
      unique case (phase_r)
        PH_SEEK: begin
          if (pair_d) begin
            open_nxt = pos_m1;
            pv_nxt   = 1'b0;
          end
        end
        PH_INSIDE: begin
          if (pair_d) begin
            close_nxt = pos_m1;
          end else if (!f1_r) begin
            if (pair_s) begin
              sep1_nxt = pos_m1;
              f1_nxt   = 1'b1;
              pv_nxt   = 1'b0;
            end
          end else begin
            if (!f2_r && pair_s) begin
              sep2_nxt = pos_m1;
              f2_nxt   = 1'b1;
            end
            if (!fo_r && q_class.oper) begin
              oper_nxt = q_pos;
              fo_nxt   = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result fields from the current scan state.
  always_comb begin
    found_c = (phase_r == PH_CLOSED);
    kind_c  = KIND_PLAIN;
    ae_w    = '0;
    if (found_c && f1_r) begin
      if (f2_r) begin
        kind_c = KIND_OPTION;
        ae_w   = W'(sep2_r);
      end else if (fo_r && (oper_r < close_r)) begin
        kind_c = KIND_COMPARE;
        ae_w   = W'(oper_r);
      end
    end
    ts_c = '0;
    te_c = '0;
    vs_c = '0;
    ve_c = '0;
    as_c = '0;
    ae_c = '0;
    os_c = '0;
    oe_c = '0;
    if (found_c) begin
      ts_c = FIELD_W'(W'(open_r));
      te_c = FIELD_W'(W'(close_r) + W'(2));
      vs_c = FIELD_W'(W'(open_r) + W'(2));
      ve_c = FIELD_W'(W'(close_r));
      if (kind_c != KIND_PLAIN) begin
        ve_c = FIELD_W'(W'(sep1_r));
        as_c = FIELD_W'(W'(sep1_r) + W'(2));
        ae_c = FIELD_W'(ae_w);
        os_c = FIELD_W'(ae_w + W'(2));
        oe_c = FIELD_W'(W'(close_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEEK;
      pv_r        <= 1'b0;
      open_r      <= '0;
      close_r     <= '0;
      sep1_r      <= '0;
      sep2_r      <= '0;
      oper_r      <= '0;
      f1_r        <= 1'b0;
      f2_r        <= 1'b0;
      fo_r        <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pv_r    <= pv_nxt;
      open_r  <= open_nxt;
      close_r <= close_nxt;
      sep1_r  <= sep1_nxt;
      sep2_r  <= sep2_nxt;
      oper_r  <= oper_nxt;
      f1_r    <= f1_nxt;
      f2_r    <= f2_nxt;
      fo_r    <= fo_nxt;
      ovf_r   <= ovf_nxt;
      if (q_pop && q_class.term) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_class.term) begin
      found_r <= found_c;
      kind_r  <= kind_c;
      ts_r    <= ts_c;
      te_r    <= te_c;
      vs_r    <= vs_c;
      ve_r    <= ve_c;
      as_r    <= as_c;
      ae_r    <= ae_c;
      os_r    <= os_c;
      oe_r    <= oe_c;
      long_r  <= ovf_r;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.found        = found_r;
  assign out_res.segment_kind = kind_r;
  assign out_res.tag_start    = ts_r;
  assign out_res.tag_end      = te_r;
  assign out_res.var_start    = vs_r;
  assign out_res.var_end      = ve_r;
  assign out_res.attr_start   = as_r;
  assign out_res.attr_end     = ae_r;
  assign out_res.value_start  = os_r;
  assign out_res.value_end    = oe_r;
  assign out_res.too_long     = long_r;
endmodule
`default_nettype wire

/* tb/tb_template_tag_segment_scanner_core.sv */
// Self-checking testbench of the template tag segment scanner core.
module tb_template_tag_segment_scanner_core;
  import tts_pkg::*;

  localparam int unsigned MAX_CHARS    = MAX_LEN_DEF;
  localparam int          RANDOM_WORDS = 750;
  localparam int          HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int          TAIL_CYCLES  = 8;     // pipeline is two deep
  localparam int          STALL_LIMIT  = 4000;  // cycles with no handshake at all

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [FIELD_W-1:0] pos_t;

  // One result word as the scanner should report it for a string.
  typedef struct packed {
    logic       found;
    logic [1:0] segment_kind;
    pos_t       tag_start;
    pos_t       tag_end;
    pos_t       var_start;
    pos_t       var_end;
    pos_t       attr_start;
    pos_t       attr_end;
    pos_t       value_start;
    pos_t       value_end;
    logic       too_long;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  char_t cfg_wdata;

  tts_in_if  in_if ();
  tts_out_if out_if ();

  template_tag_segment_scanner_core #(
    .MAX_LEN(MAX_CHARS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_res  (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scanner state as the testbench tracks it, plus the delimiter settings.
  // ---------------------------------------------------------------------------
  char_t      cur_delim = DELIM_RST;
  char_t      cur_sep   = SEP_RST;
  int         scan_pos  = 0;
  char_t      prev_ch   = '0;
  bit         prev_ok   = 1'b0;
  tts_phase_t phase     = PH_SEEK;
  int         open_pos  = 0;
  int         close_pos = 0;
  int         sep1_pos  = 0;
  int         sep2_pos  = 0;
  int         op_pos    = 0;
  bit         have_sep1 = 1'b0;
  bit         have_sep2 = 1'b0;
  bit         have_op   = 1'b0;
  bit         overflow  = 1'b0;

  scan_result_t pending_results[$];   // results owed by the scanner, oldest first
  char_t        line_buf[$];          // string being built for the next send

  int  mismatch_count  = 0;
  int  words_sent      = 0;
  int  strings_sent    = 0;
  int  tags_predicted  = 0;
  int  long_strings    = 0;
  int  settings_loaded = 0;
  bit  send_burst      = 1'b0;
  bit  recv_burst      = 1'b0;
  int  hold_request    = 0;

  // Operator characters: ! = < > & |
  function automatic char_t oper_at(input int k);
    case (k)
      0:       return 8'h21;
      1:       return 8'h3D;
      2:       return 8'h3C;
      3:       return 8'h3E;
      4:       return 8'h26;
      default: return 8'h7C;
    endcase
  endfunction

  function automatic bit is_oper_char(input char_t c);
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < 6; k++) hit |= (c == oper_at(k));
    return hit;
  endfunction

  // Form the bounds of the first tag from what the scan has marked so far.
  function automatic scan_result_t tag_bounds();
    scan_result_t r;
    int           ae;
    r          = '0;
    r.too_long = overflow;
    if (phase == PH_CLOSED) begin
      r.found        = 1'b1;
      r.segment_kind = KIND_PLAIN;
      r.tag_start    = pos_t'(open_pos);
      r.tag_end      = pos_t'(close_pos + 2);
      r.var_start    = pos_t'(open_pos + 2);
      r.var_end      = pos_t'(close_pos);
      ae             = 0;
      if (have_sep1) begin
        // A second doubled separator wins over any operator.
        if (have_sep2) begin
          r.segment_kind = KIND_OPTION;
          ae             = sep2_pos;
        end else if (have_op && op_pos < close_pos) begin
          r.segment_kind = KIND_COMPARE;
          ae             = op_pos;
        end
        if (r.segment_kind != KIND_PLAIN) begin
          r.var_end     = pos_t'(sep1_pos);
          r.attr_start  = pos_t'(sep1_pos + 2);
          r.attr_end    = pos_t'(ae);
          r.value_start = pos_t'(ae + 2);
          r.value_end   = pos_t'(close_pos);
        end
      end
    end
    return r;
  endfunction

  // Advance the tracked scan by one accepted word; queue a result on a terminator.
  task automatic track_char(input char_t ch, input logic term);
    bit pair_d;
    bit pair_s;
    bit keep_prev;
    scan_result_t r;
    if (term) begin
      r = tag_bounds();
      if (r.found) tags_predicted++;
      pending_results.push_back(r);
      scan_pos  = 0;
      prev_ch   = '0;
      prev_ok   = 1'b0;
      phase     = PH_SEEK;
      open_pos  = 0;
      close_pos = 0;
      sep1_pos  = 0;
      sep2_pos  = 0;
      op_pos    = 0;
      have_sep1 = 1'b0;
      have_sep2 = 1'b0;
      have_op   = 1'b0;
      overflow  = 1'b0;
      return;
    end
    // Drop characters past the length limit; they match nothing.
    if (scan_pos >= MAX_CHARS) begin
      overflow = 1'b1;
      return;
    end
    pair_d    = prev_ok && prev_ch == cur_delim && ch == cur_delim;
    pair_s    = prev_ok && prev_ch == cur_sep && ch == cur_sep;
    keep_prev = 1'b1;
    case (phase)
      PH_SEEK: begin
        if (pair_d) begin
          open_pos  = scan_pos - 1;
          phase     = PH_INSIDE;
          keep_prev = 1'b0;   // the opening pair cannot also start the closing one
        end
      end
      PH_INSIDE: begin
        if (pair_d) begin
          close_pos = scan_pos - 1;
          phase     = PH_CLOSED;
        end else if (!have_sep1) begin
          if (pair_s) begin
            sep1_pos  = scan_pos - 1;
            have_sep1 = 1'b1;
            keep_prev = 1'b0;
          end
        end else begin
          if (!have_sep2 && pair_s) begin
            sep2_pos  = scan_pos - 1;
            have_sep2 = 1'b1;
          end
          if (!have_op && is_oper_char(ch)) begin
            op_pos  = scan_pos;
            have_op = 1'b1;
          end
        end
      end
      default: ;
    endcase
    prev_ch  = ch;
    prev_ok  = keep_prev;
    scan_pos = scan_pos + 1;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one word per call, a random gap in front of it.
  // ---------------------------------------------------------------------------
  task automatic send_word(input char_t ch, input logic term);
    int gap;
    if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    // Drop valid only when a gap follows; with no gap keep it high.
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.ch         <= ch;
    in_if.terminator <= term;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    track_char(ch, term);
    words_sent++;
  endtask

  // Send the buffered string and close it with a terminator carrying junk.
  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_word(line_buf[i], 1'b0);
    send_word(char_t'($urandom_range(0, 255)), 1'b1);
    strings_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(char_t'(s[i]));
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    add_text(s);
    send_line();
  endtask

  task automatic add_pair(input char_t c);
    line_buf.push_back(c);
    line_buf.push_back(c);
  endtask

  // Noise leans on the characters that steer the scan.
  function automatic char_t pick_noise();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return cur_delim;
    if (r < 40) return cur_sep;
    if (r < 55) return oper_at($urandom_range(0, 5));
    return char_t'($urandom_range(0, 255));
  endfunction

  task automatic add_noise(input int n);
    repeat (n) line_buf.push_back(pick_noise());
  endtask

  task automatic add_body(input int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 85) line_buf.push_back(char_t'($urandom_range(8'h61, 8'h7A)));
      else line_buf.push_back(pick_noise());
    end
  endtask

  // Well-formed tag in any of its forms, with noise around it.
  task automatic build_template();
    int form;
    form = $urandom_range(0, 3);
    add_noise($urandom_range(0, 4));
    add_pair(cur_delim);
    add_body($urandom_range(0, 4));
    if (form != 0) begin
      add_pair(cur_sep);
      add_body($urandom_range(0, 4));
    end
    case (form)
      1: begin
        add_pair(cur_sep);
        add_body($urandom_range(0, 4));
      end
      2: begin
        line_buf.push_back(oper_at($urandom_range(0, 5)));
        line_buf.push_back(oper_at($urandom_range(0, 5)));
        add_body($urandom_range(0, 4));
      end
      3: line_buf.push_back(oper_at($urandom_range(0, 5)));  // operator hugs the close
      default: ;
    endcase
    add_pair(cur_delim);
    add_noise($urandom_range(0, 4));
  endtask

  // Hold input, wait for every owed result, then let the pipeline drain.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Load both registers while idle, plus one write to an unused index.
  task automatic load_delimiters(input char_t delim, input char_t sep);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_TAG_DELIMITER;
    cfg_wdata <= delim;
    @(posedge clk);
    cur_delim = delim;
    cfg_index <= REG_SEGMENT_SEPARATOR;
    cfg_wdata <= sep;
    @(posedge clk);
    cur_sep = sep;
    cfg_index <= CFG_IDX_W'($urandom_range(2, 255));
    cfg_wdata <= char_t'($urandom_range(0, 255));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset delimiters '@' and ':' and every form of tag.
  task automatic test_reset_defaults();
    send_text("");                // terminator alone: no tag
    send_text("x@@ab@@y");        // plain variable
    send_text("@@a::b::c@@");     // option form
    send_text("@@a::b!=c@@");     // comparison form
    send_text("@@a::b>@@");       // operator right before the close
    send_text("@@@@");            // close starts two past the open
    send_text("@@ab");            // tag never closed
    send_text("@@a::b@@::c=d");   // second separator and operator after the close
    send_text("@@a:b=c@@");       // single separator does not count
  endtask

  // Register corners: equal characters, operator as delimiter, byte extremes.
  task automatic test_register_corners();
    load_delimiters(8'h40, 8'h40);
    send_text("@@a@@b@@");        // shared pair closes the tag
    send_text("@@a::b@@");
    load_delimiters(8'h3D, SEP_RST);
    send_text("==a::b==");        // operator char that is the closing delimiter
    send_text("==a::b=c==");
    load_delimiters(8'h00, 8'hFF);
    line_buf = {8'h00, 8'h00, 8'h78, 8'hFF, 8'hFF, 8'h79, 8'h3C, 8'h7A, 8'h00, 8'h00};
    send_line();
    load_delimiters(8'hFF, 8'h00);
    line_buf = {8'hFF, 8'hFF, 8'h00, 8'h00, 8'h61, 8'h00, 8'h00, 8'h62, 8'hFF, 8'hFF};
    send_line();
  endtask

  // String past the length limit.
  task automatic test_over_long();
    load_delimiters(DELIM_RST, SEP_RST);
    // Tag ends exactly at the limit for the widest positions; the pair after
    // it falls past the limit and is dropped.
    line_buf.delete();
    repeat (MAX_CHARS - 4) line_buf.push_back(8'h78);
    add_text("@@@@@@");
    send_line();
    long_strings += 1;
  endtask

  // Receiver holds off while short strings keep coming, so input backs up.
  task automatic test_backpressure();
    send_burst   = 1'b1;
    hold_request = HOLD_CYCLES;
    repeat (30) send_text("@@a@@");
  endtask

  // Random strings, mostly well-formed, under changing delimiter settings.
  task automatic test_random_strings();
    int    start_words;
    int    lines;
    char_t c;
    start_words = words_sent;
    lines       = 0;
    while (words_sent - start_words < RANDOM_WORDS) begin
      if (lines % 8 == 7) begin
        c = char_t'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
          0:       load_delimiters(DELIM_RST, SEP_RST);
          1:       load_delimiters(8'h00, 8'hFF);
          2:       load_delimiters(8'hFF, 8'h00);
          3:       load_delimiters(c, c);
          default: load_delimiters(c, char_t'($urandom_range(0, 255)));
        endcase
      end
      line_buf.delete();
      case ($urandom_range(0, 7))
        0:       add_noise($urandom_range(0, 12));
        1: begin
          // Cut a tag short at a random point.
          build_template();
          repeat ($urandom_range(1, 4)) if (line_buf.size() != 0) void'(line_buf.pop_back());
        end
        default: build_template();
      endcase
      send_line();
      lines++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall before each result word, and the long hold on request.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        if ($urandom_range(0, 9) == 0) recv_burst = !recv_burst;
        stall = recv_burst ? 0 : $urandom_range(0, 17);
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking against the oldest owed result.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input pos_t want, input pos_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    scan_result_t want;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with no string outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("found", pos_t'(want.found), pos_t'(out_if.found));
        check_field("segment_kind", pos_t'(want.segment_kind), pos_t'(out_if.segment_kind));
        check_field("tag_start", want.tag_start, out_if.tag_start);
        check_field("tag_end", want.tag_end, out_if.tag_end);
        check_field("var_start", want.var_start, out_if.var_start);
        check_field("var_end", want.var_end, out_if.var_end);
        check_field("attr_start", want.attr_start, out_if.attr_start);
        check_field("attr_end", want.attr_end, out_if.attr_end);
        check_field("value_start", want.value_start, out_if.value_start);
        check_field("value_end", want.value_end, out_if.value_end);
        check_field("too_long", pos_t'(want.too_long), pos_t'(out_if.too_long));
      end
    end
  end

  // Stop a hung run: count cycles in which neither channel moves a word.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value before the first edge.
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    in_if.valid      <= 1'b0;
    in_if.ch         <= '0;
    in_if.terminator <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_register_corners();
    test_over_long();
    test_backpressure();
    test_random_strings();

    // Drain: every owed result in, then a few quiet cycles for stray words.
    settle();
    $display("Scanned %0d strings in %0d words, %0d with a complete tag, %0d over the limit",
             strings_sent, words_sent, tags_predicted, long_strings);
    $display("Covered %0d delimiter/separator settings and a %0d-cycle receiver hold-off",
             settings_loaded, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
